// ----- rtl/rfpf_pkg.sv -----
// Package for the radar frame parser with presence filter.
// Holds sizes, frame codes, status codes and the structs shared between the modules.
// Depends on nothing.
`timescale 1ns / 1ps

package rfpf_pkg;

    localparam int MAX_PAYLOAD  = 512;
    localparam int HISTORY_BITS = 8;
    localparam int HDR_LEN      = 8;
    localparam int CAP_LEN      = 12;
    localparam int POS_W        = $clog2(MAX_PAYLOAD + HDR_LEN + 1);
    localparam int LEN_W        = $clog2(MAX_PAYLOAD + 1);
    localparam int CFG_W        = 4;
    localparam int CFG_IDX_W    = 2;

    localparam logic [7:0] SOF_BYTE = 8'h01;

    localparam logic [15:0] TYPE_PHASE    = 16'h0A13;
    localparam logic [15:0] TYPE_A14      = 16'h0A14;
    localparam logic [15:0] TYPE_A15      = 16'h0A15;
    localparam logic [15:0] TYPE_A16      = 16'h0A16;
    localparam logic [15:0] TYPE_PRESENCE = 16'h0F09;
    localparam logic [15:0] TYPE_FFFF     = 16'hFFFF;

    localparam int MIN_LEN_PHASE    = 12;
    localparam int MIN_LEN_SHORT    = 4;
    localparam int MIN_LEN_A16      = 8;
    localparam int MIN_LEN_PRESENCE = 1;

    localparam logic [CFG_W-1:0] WINDOW_RESET   = 4'd5;
    localparam logic [CFG_W-1:0] REQ_TRUE_RESET = 4'd3;
    localparam logic [CFG_W-1:0] REQ_FALSE_RESET = 4'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW    = 2'd0,
        CFG_REQ_TRUE  = 2'd1,
        CFG_REQ_FALSE = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CHECK   = 2'd1,
        ST_REJECT  = 2'd2,
        ST_OVERLEN = 2'd3
    } status_t;

    typedef struct packed {
        logic [CFG_W-1:0] window_samples;
        logic [CFG_W-1:0] required_true;
        logic [CFG_W-1:0] required_false;
    } cfg_t;

    typedef struct packed {
        logic             emit;
        logic             over_len;
        logic             check_ok;
        logic [15:0]      frame_type;
        logic [LEN_W-1:0] len;
        logic [31:0]      word0;
        logic [31:0]      word1;
        logic [31:0]      word2;
    } frame_evt_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] frame_type;
        logic [31:0] word0;
        logic [31:0] word1;
        logic [31:0] word2;
        logic        presence_stable;
        logic        presence_stable_known;
        logic        presence_started;
        logic [31:0] valid_count;
        logic [31:0] checksum_error_count;
        logic [31:0] parse_error_count;
        logic [7:0]  consecutive_errors;
    } result_t;

endpackage

// ----- rtl/rfpf_parser.sv -----
// Byte-level frame parser: start-byte hunt, header capture, payload capture and checks.
// Depends on rfpf_pkg.
`timescale 1ns / 1ps

module rfpf_parser import rfpf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] rx_byte,
    output frame_evt_t evt
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       dxor_reg, dxor_next;
    logic [7:0]       hdr_reg [HDR_LEN];
    logic [7:0]       cap_reg [CAP_LEN];

    logic             hunting;
    logic             in_header;
    logic [POS_W-1:0] idx;
    logic             in_payload;
    logic [15:0]      hdr_len;
    logic [7:0]       hdr_xor;
    logic             sof_seen;

    always_comb
    begin
        hunting    = (pos_reg == '0);
        in_header  = !hunting && (pos_reg < POS_W'(HDR_LEN));
        idx        = pos_reg - POS_W'(HDR_LEN);
        in_payload = !hunting && !in_header && (idx < POS_W'(len_reg));
        sof_seen   = hunting && (rx_byte == SOF_BYTE);
        hdr_len    = {hdr_reg[3], hdr_reg[4]};
        hdr_xor    = '0;
        for (int i = 0; i < HDR_LEN - 1; i++)
        begin
            hdr_xor = hdr_xor ^ hdr_reg[i];
        end

        pos_next  = pos_reg;
        len_next  = len_reg;
        dxor_next = dxor_reg;

        evt            = '0;
        evt.frame_type = {hdr_reg[5], hdr_reg[6]};
        evt.len        = len_reg;
        evt.word0      = {cap_reg[3], cap_reg[2], cap_reg[1], cap_reg[0]};
        evt.word1      = {cap_reg[7], cap_reg[6], cap_reg[5], cap_reg[4]};
        evt.word2      = {cap_reg[11], cap_reg[10], cap_reg[9], cap_reg[8]};
        evt.check_ok   = (~hdr_xor == hdr_reg[HDR_LEN-1]) && (~dxor_reg == rx_byte);

        if (hunting)
        begin
            if (sof_seen)
            begin
                pos_next  = POS_W'(1);
                len_next  = '0;
                dxor_next = '0;
            end
        end
        else if (in_header)
        begin
            if (pos_reg == POS_W'(HDR_LEN - 1))
            begin
                if (hdr_len > 16'(MAX_PAYLOAD))
                begin
                    evt.emit     = 1'b1;
                    evt.over_len = 1'b1;
                    pos_next     = '0;
                    len_next     = '0;
                end
                else
                begin
                    len_next = hdr_len[LEN_W-1:0];
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
        else if (in_payload)
        begin
            dxor_next = dxor_reg ^ rx_byte;
            pos_next  = pos_reg + POS_W'(1);
        end
        else
        begin
            evt.emit = 1'b1;
            pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            len_reg  <= '0;
            dxor_reg <= '0;
            for (int k = 0; k < CAP_LEN; k++)
            begin
                cap_reg[k] <= '0;
            end
        end
        else if (fire)
        begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            dxor_reg <= dxor_next;
            for (int k = 0; k < CAP_LEN; k++)
            begin
                if (sof_seen)
                begin
                    cap_reg[k] <= '0;
                end
                else if (in_payload && (idx == POS_W'(k)))
                begin
                    cap_reg[k] <= rx_byte;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && (hunting ? sof_seen : in_header))
        begin
            hdr_reg[pos_reg[2:0]] <= rx_byte;
        end
    end

endmodule

// ----- rtl/rfpf_tracker.sv -----
// Frame outcome tracker: payload rules, counters, error run and presence majority filter.
// Depends on rfpf_pkg; takes frame events from rfpf_parser.
`timescale 1ns / 1ps

module rfpf_tracker import rfpf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  frame_evt_t evt,
    input  cfg_t       cfg,
    output result_t    res
);

    typedef logic [HISTORY_BITS-1:0] hist_t;

    logic [31:0]      good_reg, good_next;
    logic [31:0]      bad_reg, bad_next;
    logic [31:0]      rej_reg, rej_next;
    logic [7:0]       run_reg, run_next;
    hist_t            hist_reg, hist_next;
    logic [CFG_W-1:0] fill_reg, fill_next;
    logic             stable_reg, stable_next;
    logic             known_reg, known_next;

    logic [CFG_W-1:0] win;
    hist_t            mask;
    hist_t            hist_shift;
    logic [CFG_W-1:0] fill_inc;
    logic [CFG_W-1:0] count;
    logic             pay_ok;
    logic             is_presence;
    logic             raw;
    logic             started;
    logic [7:0]       run_bump;
    status_t          status;

    always_comb
    begin
        if (cfg.window_samples == '0)
        begin
            win = CFG_W'(1);
        end
        else if (cfg.window_samples > CFG_W'(HISTORY_BITS))
        begin
            win = CFG_W'(HISTORY_BITS);
        end
        else
        begin
            win = cfg.window_samples;
        end
        for (int i = 0; i < HISTORY_BITS; i++)
        begin
            mask[i] = (CFG_W'(i) < win);
        end

        raw        = (evt.word0[7:0] != 8'h00);
        hist_shift = ((hist_reg << 1) | HISTORY_BITS'(raw)) & mask;
        fill_inc   = (fill_reg < win) ? fill_reg + CFG_W'(1) : fill_reg;
        count      = '0;
        for (int i = 0; i < HISTORY_BITS; i++)
        begin
            count = count + CFG_W'(hist_shift[i]);
        end

        is_presence = 1'b0;
        case (evt.frame_type)
            TYPE_PHASE:
            begin
                pay_ok = (evt.len >= LEN_W'(MIN_LEN_PHASE))
                         && (evt.word0[30:23] != 8'hFF)
                         && (evt.word1[30:23] != 8'hFF)
                         && (evt.word2[30:23] != 8'hFF);
            end
            TYPE_A14, TYPE_A15, TYPE_FFFF:
            begin
                pay_ok = (evt.len >= LEN_W'(MIN_LEN_SHORT));
            end
            TYPE_A16:
            begin
                pay_ok = (evt.len >= LEN_W'(MIN_LEN_A16));
            end
            TYPE_PRESENCE:
            begin
                pay_ok      = (evt.len >= LEN_W'(MIN_LEN_PRESENCE));
                is_presence = 1'b1;
            end
            default:
            begin
                pay_ok = 1'b1;
            end
        endcase

        run_bump    = (run_reg == 8'hFF) ? run_reg : run_reg + 8'd1;
        good_next   = good_reg;
        bad_next    = bad_reg;
        rej_next    = rej_reg;
        run_next    = run_reg;
        hist_next   = hist_reg;
        fill_next   = fill_reg;
        stable_next = stable_reg;
        known_next  = known_reg;
        started     = 1'b0;

        if (evt.over_len)
        begin
            status   = ST_OVERLEN;
            rej_next = rej_reg + 32'd1;
            run_next = run_bump;
        end
        else if (!evt.check_ok)
        begin
            status   = ST_CHECK;
            bad_next = bad_reg + 32'd1;
            run_next = run_bump;
        end
        else if (!pay_ok)
        begin
            status   = ST_REJECT;
            rej_next = rej_reg + 32'd1;
            run_next = run_bump;
        end
        else
        begin
            status    = ST_OK;
            good_next = good_reg + 32'd1;
            run_next  = '0;
            if (is_presence)
            begin
                hist_next = hist_shift;
                fill_next = fill_inc;
                if (fill_inc < win)
                begin
                    known_next = 1'b0;
                end
                else if (count >= cfg.required_true)
                begin
                    stable_next = 1'b1;
                    known_next  = 1'b1;
                end
                else if ((win - count) >= cfg.required_false)
                begin
                    stable_next = 1'b0;
                    known_next  = 1'b1;
                end
                else
                begin
                    known_next = 1'b0;
                end
                started = known_next && stable_next && !stable_reg;
            end
        end

        res.status                = status;
        res.frame_type            = evt.frame_type;
        res.word0                 = evt.over_len ? 32'd0 : evt.word0;
        res.word1                 = evt.over_len ? 32'd0 : evt.word1;
        res.word2                 = evt.over_len ? 32'd0 : evt.word2;
        res.presence_stable       = stable_next;
        res.presence_stable_known = known_next;
        res.presence_started      = started;
        res.valid_count           = good_next;
        res.checksum_error_count  = bad_next;
        res.parse_error_count     = rej_next;
        res.consecutive_errors    = run_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            good_reg   <= '0;
            bad_reg    <= '0;
            rej_reg    <= '0;
            run_reg    <= '0;
            hist_reg   <= '0;
            fill_reg   <= '0;
            stable_reg <= 1'b0;
            known_reg  <= 1'b0;
        end
        else if (fire)
        begin
            good_reg   <= good_next;
            bad_reg    <= bad_next;
            rej_reg    <= rej_next;
            run_reg    <= run_next;
            hist_reg   <= hist_next;
            fill_reg   <= fill_next;
            stable_reg <= stable_next;
            known_reg  <= known_next;
        end
    end

endmodule

// ----- rtl/radar_frame_parser_presence_filter_core.sv -----
// Top level of the radar frame parser with presence filter.
// Depends on rfpf_pkg, rfpf_parser and rfpf_tracker.
`timescale 1ns / 1ps

// The core takes one received byte per clock cycle and yields one result beat for each
// finished or rejected frame. A byte is held in an input register while the parser and
// tracker process it; the result of a frame-ending byte is captured in the output register.
// Bytes that end no frame keep flowing while a result waits on out_stall; only a frame-ending
// byte waits for the output register to free.
module radar_frame_parser_presence_filter_core import rfpf_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           rx_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic [15:0]          frame_type,
    output logic [31:0]          word0,
    output logic [31:0]          word1,
    output logic [31:0]          word2,
    output logic                 presence_stable,
    output logic                 presence_stable_known,
    output logic                 presence_started,
    output logic [31:0]          valid_count,
    output logic [31:0]          checksum_error_count,
    output logic [31:0]          parse_error_count,
    output logic [7:0]           consecutive_errors
);

    cfg_t       cfg_reg;
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       out_valid_reg;
    result_t    res_reg;

    frame_evt_t evt;
    result_t    res;
    logic       out_free;
    logic       s1_fire;
    logic       emit_fire;

    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && (!evt.emit || out_free);
    assign emit_fire = s1_fire && evt.emit;
    assign in_stall  = s1_valid_reg && !s1_fire;

    rfpf_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (s1_fire),
        .rx_byte (s1_byte_reg),
        .evt     (evt)
    );

    rfpf_tracker u_tracker (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (emit_fire),
        .evt   (evt),
        .cfg   (cfg_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_samples <= WINDOW_RESET;
            cfg_reg.required_true  <= REQ_TRUE_RESET;
            cfg_reg.required_false <= REQ_FALSE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW:    cfg_reg.window_samples <= cfg_data;
                CFG_REQ_TRUE:  cfg_reg.required_true  <= cfg_data;
                CFG_REQ_FALSE: cfg_reg.required_false <= cfg_data;
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= rx_byte;
        end
        if (emit_fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid             = out_valid_reg;
    assign status                = res_reg.status;
    assign frame_type            = res_reg.frame_type;
    assign word0                 = res_reg.word0;
    assign word1                 = res_reg.word1;
    assign word2                 = res_reg.word2;
    assign presence_stable       = res_reg.presence_stable;
    assign presence_stable_known = res_reg.presence_stable_known;
    assign presence_started      = res_reg.presence_started;
    assign valid_count           = res_reg.valid_count;
    assign checksum_error_count  = res_reg.checksum_error_count;
    assign parse_error_count     = res_reg.parse_error_count;
    assign consecutive_errors    = res_reg.consecutive_errors;

    a_overlen_words_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OVERLEN) |-> (word0 == '0) && (word1 == '0) && (word2 == '0))
        else $error("over-length result carries payload words");

    a_started_is_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && presence_started |->
            presence_stable && presence_stable_known && (status == ST_OK))
        else $error("presence start pulse without a stable good presence frame");

    a_ok_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK) |-> (consecutive_errors == 8'd0))
        else $error("good frame left a nonzero error run");

    a_result_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(emit_fire))
        else $error("result appeared without a frame-ending byte");

endmodule

// ----- bench/rfpf_result_checker.sv -----
// Result checker for the radar frame parser with presence filter.
// Watches the configuration port and both channels, predicts each result and compares it.
// Depends on rfpf_pkg.
`timescale 1ns / 1ps

module rfpf_result_checker import rfpf_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [7:0]           rx_byte,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [1:0]           status,
    input  logic [15:0]          frame_type,
    input  logic [31:0]          word0,
    input  logic [31:0]          word1,
    input  logic [31:0]          word2,
    input  logic                 presence_stable,
    input  logic                 presence_stable_known,
    input  logic                 presence_started,
    input  logic [31:0]          valid_count,
    input  logic [31:0]          checksum_error_count,
    input  logic [31:0]          parse_error_count,
    input  logic [7:0]           consecutive_errors,
    output int                   mismatches,
    output int                   results_due
);

    logic [CFG_W-1:0] win_reg;
    logic [CFG_W-1:0] need_true;
    logic [CFG_W-1:0] need_false;

    int unsigned pos;
    int unsigned plen;
    logic [7:0]  hdr [HDR_LEN];
    logic [7:0]  cap [CAP_LEN];
    logic [7:0]  dxor;
    logic [31:0] good_cnt;
    logic [31:0] check_cnt;
    logic [31:0] reject_cnt;
    logic [7:0]  err_run;
    logic [7:0]  hist;
    int unsigned fill;
    logic        stable;
    logic        known;

    result_t frames_due [$];
    int      bad_fields = 0;

    assign mismatches = bad_fields;

    function automatic logic [31:0] cap_word(input int k);
        return {cap[4*k+3], cap[4*k+2], cap[4*k+1], cap[4*k]};
    endfunction

    function automatic void bump_errors();
        if (err_run != 8'hFF)
            err_run++;
    endfunction

    function automatic bit presence_vote(input bit raw);
        int unsigned w;
        int unsigned hits;
        logic [7:0]  mask;
        logic        prev;
        prev = stable;
        w = win_reg;
        if (w < 1)
            w = 1;
        if (w > HISTORY_BITS)
            w = HISTORY_BITS;
        mask = 8'((1 << w) - 1);
        hist = {hist[6:0], raw} & mask;
        if (fill < w)
            fill++;
        if (fill < w)
        begin
            known = 1'b0;
            return 1'b0;
        end
        hits = $countones(hist);
        if (hits >= need_true)
        begin
            stable = 1'b1;
            known = 1'b1;
        end
        else if (w - hits >= need_false)
        begin
            stable = 1'b0;
            known = 1'b1;
        end
        else
            known = 1'b0;
        return known && stable && !prev;
    endfunction

    function automatic bit payload_ok(input logic [15:0] ftype, output bit started);
        logic [31:0] wv;
        started = 1'b0;
        case (ftype)
            TYPE_PHASE:
            begin
                if (plen < MIN_LEN_PHASE)
                    return 1'b0;
                for (int k = 0; k < 3; k++)
                begin
                    wv = cap_word(k);
                    if (wv[30:23] == 8'hFF)
                        return 1'b0;
                end
                return 1'b1;
            end
            TYPE_A14, TYPE_A15, TYPE_FFFF: return plen >= MIN_LEN_SHORT;
            TYPE_A16: return plen >= MIN_LEN_A16;
            TYPE_PRESENCE:
            begin
                if (plen < MIN_LEN_PRESENCE)
                    return 1'b0;
                started = presence_vote(cap[0] != 8'h00);
                return 1'b1;
            end
            default: return 1'b1;
        endcase
    endfunction

    function automatic result_t frame_report(input status_t st, input bit started);
        result_t r;
        r.status                = st;
        r.frame_type            = {hdr[5], hdr[6]};
        r.word0                 = cap_word(0);
        r.word1                 = cap_word(1);
        r.word2                 = cap_word(2);
        r.presence_stable       = stable;
        r.presence_stable_known = known;
        r.presence_started      = started;
        r.valid_count           = good_cnt;
        r.checksum_error_count  = check_cnt;
        r.parse_error_count     = reject_cnt;
        r.consecutive_errors    = err_run;
        return r;
    endfunction

    // Advances the parser by one byte; returns 1 when the byte ends a frame.
    function automatic bit parse_byte(input logic [7:0] b, output result_t r);
        int unsigned idx;
        logic [7:0]  hx;
        logic [15:0] len16;
        bit          started;
        status_t     st;
        r = '0;
        if (pos == 0)
        begin
            if (b == SOF_BYTE)
            begin
                hdr[0] = b;
                pos = 1;
                dxor = 8'h00;
                plen = 0;
                cap = '{default: 8'h00};
            end
            return 1'b0;
        end
        if (pos < HDR_LEN)
        begin
            hdr[pos] = b;
            pos++;
            if (pos == HDR_LEN)
            begin
                len16 = {hdr[3], hdr[4]};
                if (len16 > MAX_PAYLOAD)
                begin
                    reject_cnt++;
                    bump_errors();
                    pos = 0;
                    plen = 0;
                    r = frame_report(ST_OVERLEN, 1'b0);
                    return 1'b1;
                end
                plen = len16;
            end
            return 1'b0;
        end
        idx = pos - HDR_LEN;
        if (idx < plen)
        begin
            dxor ^= b;
            if (idx < CAP_LEN)
                cap[idx] = b;
            pos++;
            return 1'b0;
        end
        hx = 8'h00;
        for (int k = 0; k < 7; k++)
            hx ^= hdr[k];
        pos = 0;
        started = 1'b0;
        if ((hx ^ hdr[7]) != 8'hFF || (dxor ^ b) != 8'hFF)
        begin
            check_cnt++;
            bump_errors();
            st = ST_CHECK;
        end
        else if (!payload_ok({hdr[5], hdr[6]}, started))
        begin
            reject_cnt++;
            bump_errors();
            st = ST_REJECT;
        end
        else
        begin
            good_cnt++;
            err_run = 8'h00;
            st = ST_OK;
        end
        r = frame_report(st, started);
        return 1'b1;
    endfunction

    function automatic void match_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            bad_fields++;
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t fresh;
        if (!rst_n)
        begin
            win_reg = WINDOW_RESET;
            need_true = REQ_TRUE_RESET;
            need_false = REQ_FALSE_RESET;
            pos = 0;
            plen = 0;
            hdr = '{default: 8'h00};
            cap = '{default: 8'h00};
            dxor = 8'h00;
            good_cnt = '0;
            check_cnt = '0;
            reject_cnt = '0;
            err_run = 8'h00;
            hist = 8'h00;
            fill = 0;
            stable = 1'b0;
            known = 1'b0;
            frames_due.delete();
            results_due <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (frames_due.size() == 0)
                begin
                    bad_fields++;
                    $display("%0t: result beat expected none actual status %0h type %0h",
                             $time, status, frame_type);
                end
                else
                begin
                    want = frames_due.pop_front();
                    match_field("status", 32'(want.status), 32'(status));
                    match_field("frame_type", 32'(want.frame_type), 32'(frame_type));
                    match_field("word0", want.word0, word0);
                    match_field("word1", want.word1, word1);
                    match_field("word2", want.word2, word2);
                    match_field("presence_stable", 32'(want.presence_stable),
                                32'(presence_stable));
                    match_field("presence_stable_known", 32'(want.presence_stable_known),
                                32'(presence_stable_known));
                    match_field("presence_started", 32'(want.presence_started),
                                32'(presence_started));
                    match_field("valid_count", want.valid_count, valid_count);
                    match_field("checksum_error_count", want.checksum_error_count,
                                checksum_error_count);
                    match_field("parse_error_count", want.parse_error_count,
                                parse_error_count);
                    match_field("consecutive_errors", 32'(want.consecutive_errors),
                                32'(consecutive_errors));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WINDOW:    win_reg = cfg_data;
                    CFG_REQ_TRUE:  need_true = cfg_data;
                    CFG_REQ_FALSE: need_false = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                if (parse_byte(rx_byte, fresh))
                    frames_due.push_back(fresh);
            results_due <= frames_due.size();
        end
    end

endmodule

// ----- bench/radar_frame_parser_presence_filter_core_test.sv -----
// Testbench top for the radar frame parser with presence filter.
// Builds byte streams of well-formed, damaged and noisy frames and gives the verdict.
// Depends on rfpf_pkg, the core and rfpf_result_checker.
`timescale 1ns / 1ps

module radar_frame_parser_presence_filter_core_test;
    import rfpf_pkg::*;

    typedef enum int {
        FAULT_NONE,
        FAULT_HDR,
        FAULT_DATA,
        FAULT_EXP
    } fault_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           rx_byte = 8'h00;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           status;
    logic [15:0]          frame_type;
    logic [31:0]          word0;
    logic [31:0]          word1;
    logic [31:0]          word2;
    logic                 presence_stable;
    logic                 presence_stable_known;
    logic                 presence_started;
    logic [31:0]          valid_count;
    logic [31:0]          checksum_error_count;
    logic [31:0]          parse_error_count;
    logic [7:0]           consecutive_errors;
    int                   mismatches;
    int                   results_due;

    bit         calm = 1'b0;
    bit         occupied = 1'b0;
    int         stall_left = 0;
    logic [7:0] tx_stream [$];

    int plan [7][3] = '{'{1, 0, 0}, '{8, 8, 8}, '{0, 1, 1}, '{15, 9, 2},
                        '{3, 15, 0}, '{8, 4, 5}, '{2, 2, 2}};

    radar_frame_parser_presence_filter_core u_top (.*);

    rfpf_result_checker u_checker (.*);

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[radar_frame_parser_presence_filter_core] ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (calm || !rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            stall_left = $urandom_range(0, 3);
        end
        else
            out_stall <= 1'b0;
    end

    task automatic add_frame(input logic [15:0] ftype, input logic [15:0] len,
                             input fault_t fault, input int lead);
        logic [7:0] h [HDR_LEN];
        logic [7:0] p [$];
        logic [7:0] x;
        int         w;
        h[0] = SOF_BYTE;
        h[1] = 8'($urandom);
        h[2] = 8'($urandom);
        h[3] = len[15:8];
        h[4] = len[7:0];
        h[5] = ftype[15:8];
        h[6] = ftype[7:0];
        x = 8'h00;
        for (int k = 0; k < 7; k++)
            x ^= h[k];
        h[7] = ~x;
        if (fault == FAULT_HDR)
            h[7] ^= 8'($urandom_range(1, 255));
        for (int k = 0; k < HDR_LEN; k++)
            tx_stream.push_back(h[k]);
        if (len > MAX_PAYLOAD)
            return;
        for (int k = 0; k < len; k++)
            p.push_back(8'($urandom));
        if (lead >= 0 && len > 0)
            p[0] = 8'(lead);
        if (fault == FAULT_EXP && len >= CAP_LEN)
        begin
            w = $urandom_range(0, 2);
            p[4*w+2][7] = 1'b1;
            p[4*w+3][6:0] = 7'h7F;
        end
        x = 8'h00;
        foreach (p[k])
        begin
            x ^= p[k];
            tx_stream.push_back(p[k]);
        end
        x = ~x;
        if (fault == FAULT_DATA)
            x ^= 8'($urandom_range(1, 255));
        tx_stream.push_back(x);
    endtask

    task automatic add_random_frame();
        int          roll;
        logic [15:0] ftype;
        logic [15:0] len;
        fault_t      fault;
        int          lead;
        logic [7:0]  b;
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            repeat ($urandom_range(1, 3))
            begin
                b = 8'($urandom);
                if (b == SOF_BYTE)
                    b = 8'h00;
                tx_stream.push_back(b);
            end
            return;
        end
        if (roll < 10)
        begin
            tx_stream.push_back(SOF_BYTE);
            repeat ($urandom_range(1, 6))
                tx_stream.push_back(8'($urandom));
            return;
        end
        lead = -1;
        fault = FAULT_NONE;
        roll = $urandom_range(0, 99);
        if (roll < 35)
        begin
            ftype = TYPE_PRESENCE;
            if ($urandom_range(0, 7) == 0)
                occupied = !occupied;
            lead = occupied ? $urandom_range(1, 255) : 0;
            if ($urandom_range(0, 9) == 0)
                lead = occupied ? 0 : $urandom_range(1, 255);
            len = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
        end
        else if (roll < 50)
        begin
            ftype = TYPE_PHASE;
            len = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 14)) : 16'd12;
            if ($urandom_range(0, 4) == 0)
                fault = FAULT_EXP;
        end
        else if (roll < 70)
        begin
            case ($urandom_range(0, 3))
                0: ftype = TYPE_A14;
                1: ftype = TYPE_A15;
                2: ftype = TYPE_A16;
                default: ftype = TYPE_FFFF;
            endcase
            len = 16'($urandom_range(0, 10));
        end
        else
        begin
            ftype = 16'($urandom);
            len = 16'($urandom_range(0, 16));
        end
        if ($urandom_range(0, 99) == 0)
            len = 16'($urandom_range(100, MAX_PAYLOAD));
        roll = $urandom_range(0, 99);
        if (roll < 5)
            fault = FAULT_HDR;
        else if (roll < 10)
            fault = FAULT_DATA;
        else if (roll < 14)
            len = $urandom_range(0, 1) ? 16'(MAX_PAYLOAD + 1)
                                       : 16'($urandom_range(MAX_PAYLOAD + 1, 65535));
        add_frame(ftype, len, fault, lead);
    endtask

    task automatic drain_stream();
        logic [7:0] b;
        while (tx_stream.size() != 0)
        begin
            b = tx_stream.pop_front();
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            in_valid <= 1'b1;
            rx_byte <= b;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
        end
        in_valid <= 1'b0;
    endtask

    task automatic reconfigure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] t,
                               input logic [CFG_W-1:0] f);
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_WINDOW;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= CFG_REQ_TRUE;
        cfg_data <= t;
        @(posedge clk);
        cfg_index <= CFG_REQ_FALSE;
        cfg_data <= f;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        tx_stream = '{8'h00, 8'hFF, 8'hAA, 8'h55};
        add_frame(TYPE_PHASE, 16'd12, FAULT_NONE, -1);
        add_frame(TYPE_PHASE, 16'd12, FAULT_EXP, -1);
        add_frame(TYPE_PHASE, 16'd11, FAULT_NONE, -1);
        add_frame(TYPE_A14, 16'd3, FAULT_NONE, -1);
        add_frame(TYPE_A15, 16'd4, FAULT_NONE, -1);
        add_frame(TYPE_FFFF, 16'd4, FAULT_NONE, -1);
        add_frame(TYPE_FFFF, 16'd0, FAULT_NONE, -1);
        add_frame(TYPE_A16, 16'd7, FAULT_NONE, -1);
        add_frame(TYPE_A16, 16'd8, FAULT_NONE, -1);
        add_frame(16'h0000, 16'd0, FAULT_NONE, -1);
        add_frame(16'h1234, 16'd5, FAULT_HDR, -1);
        add_frame(16'h4321, 16'd5, FAULT_DATA, -1);
        add_frame(16'h2222, 16'(MAX_PAYLOAD + 1), FAULT_NONE, -1);
        add_frame(16'hFFFF, 16'hFFFF, FAULT_NONE, -1);
        add_frame(16'h5555, 16'(MAX_PAYLOAD), FAULT_NONE, -1);
        add_frame(TYPE_PRESENCE, 16'd0, FAULT_NONE, -1);
        for (int k = 0; k < 6; k++)
            add_frame(TYPE_PRESENCE, 16'd1, FAULT_NONE, (k % 2) ? 8'hFF : 8'h80);
        for (int k = 0; k < 5; k++)
            add_frame(TYPE_PRESENCE, 16'd2, FAULT_NONE, 0);
        drain_stream();

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph < 7)
                reconfigure(CFG_W'(plan[ph][0]), CFG_W'(plan[ph][1]), CFG_W'(plan[ph][2]));
            else
            begin
                calm = 1'b1;
                reconfigure(CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(0, 8)),
                            CFG_W'($urandom_range(0, 8)));
            end
            while (tx_stream.size() < 100)
                add_random_frame();
            drain_stream();
        end

        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("[radar_frame_parser_presence_filter_core] OK");
        else
            $display("[radar_frame_parser_presence_filter_core] ERROR");
        $finish;
    end

endmodule
